// File: design/sfr_pkg.sv
// sfr_pkg: shared types and constants of the streaming find-and-replace block.
// No dependencies; every design file imports it.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LANES       = 8;
    localparam int WORD_W      = LANES * BYTE_W;
    localparam int LEN_W       = 4;
    localparam int HELD_DEPTH  = LANES - 1;
    localparam int HCNT_W      = 3;
    localparam int IDX_W       = 3;
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int PLEN_CAP    = (PATTERN_MAX < LANES) ? PATTERN_MAX : LANES;
    localparam int RLEN_CAP    = (REPLACE_MAX < LANES) ? REPLACE_MAX : LANES;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_ADDR_W  = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATTERN_BYTES,
        CFG_PATTERN_LENGTH,
        CFG_REPLACEMENT_BYTES,
        CFG_REPLACEMENT_LENGTH
    } t_cfg_idx;

    // one output request: cnt results taken from data, lowest byte first
    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [LEN_W-1:0]  cnt;
        logic              eot;
        logic              nochar;
    } t_job;

endpackage

`default_nettype wire

// File: design/stream_find_replace_all.sv
// stream_find_replace_all: streaming find-and-replace, top level.
// A byte's request is registered in the queue, then in the sequencer, before output.
// Throughput: one byte accepted per cycle while the queue has room; a byte
// causing k results holds the output for k results, buffered by a two-request queue.
// Reset: synchronous, active low; clears config, held count, queue, busy flag.
// Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back.
`default_nettype none

module stream_find_replace_all (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [sfr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire  [sfr_pkg::WORD_W-1:0]        i_cfg_data,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [7:0]                        i_s_axis_tdata,  // [7:0] text_byte
    input  wire                               i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // [7:0] out_byte
    output logic                              o_m_axis_tlast,
    output logic [1:0]                        o_m_axis_tuser   // [0] byte_valid, [1] text_done
);
    import sfr_pkg::*;

    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_pop;
    t_job w_pop_job;
    logic w_empty;

    sfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_eot      (i_s_axis_tlast),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_full     (w_full)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    sfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!w_empty),
        .i_job     (w_pop_job),
        .o_pop     (w_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast),
        .o_tuser   (o_m_axis_tuser)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("text_done without run_last");

    a_marker_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tlast && o_m_axis_tuser[1]))
        else $error("empty result not at end of text");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> (!w_empty && !w_push))
        else $error("queue written while full");

endmodule

`default_nettype wire

// File: design/sfr_front.sv
// sfr_front: configuration registers, held partial-match bytes and match
// classification; turns each accepted byte into at most one output request.
// Depends on sfr_pkg.
`default_nettype none

module sfr_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [sfr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire  [sfr_pkg::WORD_W-1:0]        i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire  [sfr_pkg::BYTE_W-1:0]        i_byte,
    input  wire                               i_eot,
    output logic                              o_push,
    output sfr_pkg::t_job                     o_job,
    input  wire                               i_full
);
    import sfr_pkg::*;

    logic [WORD_W-1:0] r_pat;
    logic [LEN_W-1:0]  r_plen;
    logic [WORD_W-1:0] r_repl;
    logic [LEN_W-1:0]  r_rlen;
    logic [BYTE_W-1:0] r_held [HELD_DEPTH];
    logic [HCNT_W-1:0] r_hcnt;

    logic [BYTE_W-1:0] n_held [HELD_DEPTH];
    logic [HCNT_W-1:0] n_hcnt;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  nbuf;
    logic [BYTE_W-1:0] buf_b [LANES];
    logic [LANES-1:0]  cand;
    logic [LEN_W-1:0]  p_sel;
    logic              full;
    logic [WORD_W-1:0] buf_word;
    logic              accept;
    logic              has_out;
    t_job              job;

    assign plen = (r_plen > LEN_W'(PLEN_CAP)) ? LEN_W'(PLEN_CAP) : r_plen;
    assign rlen = (r_rlen > LEN_W'(RLEN_CAP)) ? LEN_W'(RLEN_CAP) : r_rlen;
    assign nbuf = LEN_W'(r_hcnt) + LEN_W'(1);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            buf_b[i] = i_byte;
        end
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if (HCNT_W'(i) < r_hcnt) begin
                buf_b[i] = r_held[i];
            end
        end
        for (int i = 0; i < LANES; i++) begin
            buf_word[i*BYTE_W +: BYTE_W] = buf_b[i];
        end
    end

    always_comb begin
        for (int p = 0; p < LANES; p++) begin
            cand[p] = 1'b1;
            for (int i = 0; i + p < LANES; i++) begin
                if ((LEN_W'(i + p) < nbuf) && (LEN_W'(i) < plen) &&
                    (buf_b[i + p] != r_pat[i*BYTE_W +: BYTE_W])) begin
                    cand[p] = 1'b0;
                end
            end
        end
        p_sel = nbuf;
        if (plen != '0) begin
            for (int p = LANES - 1; p >= 0; p--) begin
                if ((LEN_W'(p) < nbuf) && cand[p]) begin
                    p_sel = LEN_W'(p);
                end
            end
        end
        full = (plen != '0) && cand[0] && (nbuf >= plen);
    end

    always_comb begin
        logic [LEN_W-1:0] j;
        job     = '0;
        has_out = 1'b0;
        n_hcnt  = '0;
        j       = '0;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            j = p_sel + LEN_W'(i);
            n_held[i] = (j < LEN_W'(LANES)) ? buf_b[j[IDX_W-1:0]] : '0;
        end
        job.eot = i_eot;
        if (full) begin
            job.data = r_repl;
            job.cnt  = rlen;
            has_out  = (rlen != '0);
            if (i_eot && (rlen == '0)) begin
                job.data   = '0;
                job.cnt    = LEN_W'(1);
                job.nochar = 1'b1;
                has_out    = 1'b1;
            end
        end else if (i_eot) begin
            job.data = buf_word;
            job.cnt  = nbuf;
            has_out  = 1'b1;
        end else begin
            job.data = buf_word;
            job.cnt  = p_sel;
            has_out  = (p_sel != '0);
            n_hcnt   = HCNT_W'(nbuf - p_sel);
        end
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_out;
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_repl <= '0;
            r_rlen <= '0;
            r_hcnt <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PATTERN_BYTES: begin
                    r_pat  <= i_cfg_data;
                    r_hcnt <= '0;
                end
                CFG_PATTERN_LENGTH: begin
                    r_plen <= i_cfg_data[LEN_W-1:0];
                    r_hcnt <= '0;
                end
                CFG_REPLACEMENT_BYTES: begin
                    r_repl <= i_cfg_data;
                end
                CFG_REPLACEMENT_LENGTH: begin
                    r_rlen <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            r_hcnt <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// File: design/sfr_queue.sv
// sfr_queue: short request queue between the classifying front and the
// output sequencer. Depends on sfr_pkg.
`default_nettype none

module sfr_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire sfr_pkg::t_job   i_job,
    output logic                 o_full,
    input  wire                  i_pop,
    output sfr_pkg::t_job        o_job,
    output logic                 o_empty
);
    import sfr_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: design/sfr_back.sv
// sfr_back: output sequencer; walks each request one result per cycle while
// tready is high and drives the result stream. Depends on sfr_pkg.
`default_nettype none

module sfr_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  wire sfr_pkg::t_job           i_job,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  wire                          i_tready,
    output logic [sfr_pkg::BYTE_W-1:0]   o_tdata,
    output logic                         o_tlast,
    output logic [1:0]                   o_tuser
);
    import sfr_pkg::*;

    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic             last;
    logic             hs;
    logic             load;

    assign last     = (r_idx == IDX_W'(r_job.cnt - LEN_W'(1)));
    assign hs       = r_busy && i_tready;
    assign load     = i_q_valid && (!r_busy || (hs && last));
    assign o_pop    = load;
    assign o_tvalid = r_busy;
    assign o_tdata  = r_job.data[r_idx*BYTE_W +: BYTE_W];
    assign o_tlast  = last;
    assign o_tuser  = {r_job.eot && last, !r_job.nochar};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (hs) begin
            if (last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

endmodule

`default_nettype wire
